>>> sv/tor_pkg.sv
package tor_pkg;

  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;

  localparam int unsigned TtypeLen = 10;
  localparam int unsigned IdxW     = $clog2(TtypeLen);

  // IAC SB TTYPE IS "ANSI" IAC SE
  localparam logic [7:0] TTYPE_REPLY [TtypeLen] = '{
    8'd255, 8'd250, 8'd24, 8'd0, 8'd65, 8'd78, 8'd83, 8'd73, 8'd255, 8'd240
  };

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_DATA,
    RESP_TRIPLE,
    RESP_TTYPE
  } resp_kind_e;

  // One decoded request for the emitter.
  typedef struct packed {
    resp_kind_e kind;
    logic [7:0] verb;
    logic [7:0] data;
  } resp_t;

endpackage

>>> sv/tor_parser.sv
module tor_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_eob_i,
  output logic               resp_valid_o,
  input  logic               resp_ready_i,
  output tor_pkg::resp_t     resp_o
);

  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_CMD,
    MODE_OPT,
    MODE_SUB
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eob_q;

  logic in_fire;
  logic resp_fire;
  logic sub_end;
  logic opt_known;
  tor_pkg::resp_t resp;

  assign resp_fire    = in_valid_q && resp_ready_i;
  assign in_ready_o   = !in_valid_q || resp_ready_i;
  assign in_fire      = in_valid_i && in_ready_o;
  assign resp_valid_o = in_valid_q;
  assign resp_o       = resp;
  assign sub_end      = (in_byte_q == tor_pkg::CMD_SE) || in_eob_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (resp_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    resp.kind = tor_pkg::RESP_NONE;
    resp.verb = tor_pkg::CMD_WONT;
    resp.data = in_byte_q;
    opt_known = 1'b0;
    case (mode_q)
      MODE_DATA: begin
        if (in_byte_q == tor_pkg::CMD_IAC) begin
          mode_d = in_eob_q ? MODE_DATA : MODE_CMD;
        end else begin
          resp.kind = tor_pkg::RESP_DATA;
        end
      end
      MODE_CMD: begin
        held_d = in_byte_q;
        mode_d = in_eob_q ? MODE_DATA : MODE_OPT;
      end
      MODE_OPT: begin
        mode_d = MODE_DATA;
        if (held_q == tor_pkg::CMD_SB) begin
          if (sub_end) begin
            resp.kind = tor_pkg::RESP_TTYPE;
          end else begin
            mode_d = MODE_SUB;
          end
        end else begin
          case (held_q)
            tor_pkg::CMD_DO: begin
              opt_known = (in_byte_q == tor_pkg::OPT_SGA) ||
                          (in_byte_q == tor_pkg::OPT_TTYPE);
              resp.kind = tor_pkg::RESP_TRIPLE;
              resp.verb = opt_known ? tor_pkg::CMD_WILL : tor_pkg::CMD_WONT;
            end
            tor_pkg::CMD_WILL, tor_pkg::CMD_WONT: begin
              opt_known = in_byte_q inside {tor_pkg::OPT_ECHO, tor_pkg::OPT_SGA,
                                            tor_pkg::OPT_TTYPE};
              resp.kind = tor_pkg::RESP_TRIPLE;
              resp.verb = opt_known ? tor_pkg::CMD_DO : tor_pkg::CMD_DONT;
            end
            tor_pkg::CMD_DONT: begin
              resp.kind = tor_pkg::RESP_TRIPLE;
              resp.verb = tor_pkg::CMD_WONT;
            end
            default: begin
              resp.kind = tor_pkg::RESP_NONE;
            end
          endcase
        end
      end
      MODE_SUB: begin
        if (sub_end) begin
          mode_d    = MODE_DATA;
          resp.kind = tor_pkg::RESP_TTYPE;
        end
      end
      default: begin
        mode_d = MODE_DATA;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DATA;
      held_q     <= 8'd0;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (resp_fire) begin
        mode_q <= mode_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_byte_i;
      in_eob_q  <= in_eob_i;
    end
  end

  // A finished command always leaves the parser in data mode.
  a_triple_to_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_fire && resp.kind == tor_pkg::RESP_TRIPLE |=> mode_q == MODE_DATA)
    else $error("parser not back in data mode after answering a command");

  // Terminal-type reply only comes out of a sub-negotiation.
  a_ttype_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && resp.kind == tor_pkg::RESP_TTYPE |->
      (mode_q == MODE_OPT && held_q == tor_pkg::CMD_SB) || mode_q == MODE_SUB)
    else $error("terminal-type reply outside sub-negotiation");

endmodule

>>> sv/tor_emitter.sv
module tor_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               resp_valid_i,
  output logic               resp_ready_o,
  input  tor_pkg::resp_t     resp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_peer_o,
  output logic               out_last_o
);

  localparam logic [tor_pkg::IdxW-1:0] TripleLast = tor_pkg::IdxW'(2);
  localparam logic [tor_pkg::IdxW-1:0] TtypeLast  = tor_pkg::IdxW'(tor_pkg::TtypeLen - 1);

  logic                      busy_q, busy_d;
  tor_pkg::resp_kind_e       kind_q;
  logic [7:0]                verb_q, opt_q;
  logic [tor_pkg::IdxW-1:0]  idx_q;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                out_byte_q;
  logic                      out_peer_q, out_last_q;

  tor_pkg::resp_kind_e       cur_kind;
  logic [7:0]                cur_verb, cur_opt, cur_byte;
  logic [tor_pkg::IdxW-1:0]  cur_idx;
  logic                      cur_last;
  logic                      load_ok, emit;

  assign load_ok      = !out_valid_q || out_ready_i;
  assign resp_ready_o = !busy_q && (load_ok || resp_i.kind == tor_pkg::RESP_NONE);
  assign emit         = load_ok &&
                        (busy_q || (resp_valid_i && resp_i.kind != tor_pkg::RESP_NONE));

  assign cur_kind = busy_q ? kind_q : resp_i.kind;
  assign cur_verb = busy_q ? verb_q : resp_i.verb;
  assign cur_opt  = busy_q ? opt_q  : resp_i.data;
  assign cur_idx  = busy_q ? idx_q  : '0;

  always_comb begin
    cur_byte = cur_opt;
    cur_last = 1'b1;
    case (cur_kind)
      tor_pkg::RESP_TRIPLE: begin
        cur_last = (cur_idx == TripleLast);
        if (cur_idx == '0) begin
          cur_byte = tor_pkg::CMD_IAC;
        end else if (cur_idx == tor_pkg::IdxW'(1)) begin
          cur_byte = cur_verb;
        end
      end
      tor_pkg::RESP_TTYPE: begin
        cur_last = (cur_idx >= TtypeLast);
        cur_byte = tor_pkg::TTYPE_REPLY[cur_idx];
      end
      default: begin
        cur_byte = cur_opt;
        cur_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    if (emit) begin
      out_valid_d = 1'b1;
      busy_d      = !cur_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= cur_kind;
      verb_q     <= cur_verb;
      opt_q      <= cur_opt;
      idx_q      <= cur_idx + tor_pkg::IdxW'(1);
      out_byte_q <= cur_byte;
      out_peer_q <= (cur_kind != tor_pkg::RESP_DATA);
      out_last_q <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_peer_o  = out_peer_q;
  assign out_last_o  = out_last_q;

  // Only multi-byte replies keep the sequencer busy.
  a_busy_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> kind_q == tor_pkg::RESP_TRIPLE || kind_q == tor_pkg::RESP_TTYPE)
    else $error("sequencer busy on single-byte request");

  // Terminal data is never split, so a non-final byte is a reply byte.
  a_mid_is_peer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_peer_q && busy_q)
    else $error("non-final byte not part of an ongoing reply");

endmodule

>>> sv/telnet_option_responder.sv
// Telnet option responder.
// Slave stream: one received telnet byte per request; tlast marks the last
// byte of a receive buffer. Master stream: bytes for the terminal
// (tuser = 0) or replies to the peer (tuser = 1); tlast marks the final
// byte caused by one input byte. Bytes that end up swallowed cause nothing.
// The first output byte passes the input register, then the output
// register. Throughput: plain data bytes flow at one per cycle while
// the receiver does not stall. A command answer is three output bytes
// and the terminal-type reply ten; the reply sequencer sends one byte
// per cycle while the receiver keeps up and holds the next decoded
// request meanwhile, so the input stalls while a reply is sent (one
// byte waits in the input register).
// Reset clears parser mode, held command and all valid flags; the block
// is ready for input as soon as reset is released.
// When the receiver stalls, the output register holds its byte, the
// sequencer pauses, and tready on the input drops once the input register
// holds a byte that causes output.
module telnet_option_responder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,  // end_of_buffer
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tuser_o,  // [0] to_peer
  output logic       m_axis_tlast_o   // last_of_run
);

  logic           resp_valid;
  logic           resp_ready;
  tor_pkg::resp_t resp;

  tor_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_eob_i     (s_axis_tlast_i),
    .resp_valid_o (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_o       (resp)
  );

  tor_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .resp_valid_i (resp_valid),
    .resp_ready_o (resp_ready),
    .resp_i       (resp),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_peer_o   (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
